FILE: rtl/vrt_pkg.sv
// Package for the voxel ray traversal block: widths, defaults and the sequencer state type.
// Depends on nothing; used by vrt_divider and voxel_ray_traversal_3d_top.
package vrt_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned VSIZE_W = 23;
  localparam logic [VSIZE_W-1:0] VSIZE_RESET = 23'd6554;
  localparam int unsigned MAX_VOXELS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Internal magnitude width: a Q15.24 coordinate scaled, or a voxel size scaled by 2^8.
  localparam int unsigned DW = 44;
  localparam int unsigned PW = 2 * DW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_SETUP, ST_EMIT,
    ST_MUL, ST_CMP, ST_ADVANCE
  } vrt_state_t;
endpackage

FILE: rtl/vrt_divider.sv
// Restoring radix-2 floor divider: one quotient bit per cycle.
// Depends on vrt_pkg for the operand width.
module vrt_divider import vrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW:0]   num,
  input  logic [DW-1:0]        den,
  output logic                 busy,
  output logic signed [DW:0]   quo,
  output logic [DW-1:0]        rmd
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] mag;
  logic [DW:0]   rem;
  logic [DW-1:0] q;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW:0]   trial;
  logic [DW:0]   qext;

  always_comb begin
    trial = {rem[DW-1:0], mag[DW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
      neg  <= num[DW];
      mag  <= num[DW] ? DW'(-num) : num[DW-1:0];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      mag <= {mag[DW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q   <= {q[DW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[DW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Floor for negative numerators: -(q) minus one when the remainder is non-zero,
  // and the remainder is then taken up from the divisor so that it stays non-negative.
  always_comb begin
    qext = {1'b0, q};
    if (neg) begin
      quo = (rem != '0) ? -qext - 1'b1 : -qext;
      rmd = (rem != '0) ? den - rem[DW-1:0] : '0;
    end else begin
      quo = qext;
      rmd = rem[DW-1:0];
    end
  end
endmodule

FILE: rtl/voxel_ray_traversal_3d_top.sv
// Top level of the 3D voxel ray traversal (grid DDA) block.
// Depends on vrt_pkg and vrt_divider.
//
// Usage. A ray segment (origin and endpoint, signed Q15.F metres) is offered
// on the input channel with in_valid/in_ready; a transfer takes place when
// both are high. The block then emits one output transfer per visited voxel
// on the out_valid/out_ready channel, start voxel first, with last set on the
// final voxel and truncated set when the walk stopped at the cap instead of
// at the end voxel.
// Six floor divisions run one after another through one shared restoring
// divider of 44 bits. The remainders of the origin divisions give the
// distance to the first boundary on each axis. Each further voxel then takes
// two crossing compares (y against x, then z against the winner), each made
// of two products built from 22 by 22 bit partial products on a shared
// multiplier and a decide step, then a step and an emit. in_ready is high
// only when idle, which begins once the last transfer is taken. A stalled
// receiver simply holds the current voxel on the output until it is taken;
// nothing is lost. Reset returns the sequencer to idle and sets the voxel
// size register to its default; vsize_we writes it.
module voxel_ray_traversal_3d_top import vrt_pkg::*; #(
  parameter int unsigned MAX_VOXELS      = MAX_VOXELS_DEF,
  parameter int unsigned COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vsize_we,
  input  logic [VSIZE_W-1:0]        vsize_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic signed [COORD_W-1:0] origin_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] end_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] cell_x,
  output logic signed [COORD_W-1:0] cell_y,
  output logic signed [COORD_W-1:0] cell_z,
  output logic                      last,
  output logic                      truncated
);
  localparam int unsigned CSHIFT = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
  localparam int unsigned VSHIFT = (COORD_FRAC_BITS > 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int unsigned KW     = $clog2(MAX_VOXELS + 1);
  localparam int unsigned HW     = DW / 2;

  logic [VSIZE_W-1:0] vsize;

  vrt_state_t state, state_next;

  // Scaled coordinates, indices 0..2 origin, 3..5 end.
  logic signed [DW:0] crd [6];
  logic signed [DW:0] cellv [6];
  logic [2:0]         div_idx;
  logic [DW-1:0]      vs;
  logic [DW-1:0]      bdist [3];
  logic [DW-1:0]      len  [3];
  logic [1:0]         dir  [3];   // bit1 negative, bit0 moving
  logic [DW+2:0]      manh;
  logic [KW-1:0]      limit;
  logic [KW-1:0]      k;
  logic [1:0]         best;
  logic               cmp_sel;    // 0: y against x, 1: z against the winner
  logic               prod_idx;   // which of the two cross products is being built
  logic [1:0]         part;       // partial product in progress
  logic [PW-1:0]      prod_a;
  logic [PW-1:0]      acc;
  logic               at_end, capped;
  logic               first_emit;

  logic               div_start, div_busy;
  logic signed [DW:0] div_quo;
  logic [DW-1:0]      div_rmd;

  logic [1:0]         cand, base;
  logic [DW-1:0]      mul_a, mul_b;
  logic [HW-1:0]      pa, pb;
  logic [DW-1:0]      pp;
  logic [PW-1:0]      pp_sh, acc_sum;
  logic               better;

  logic signed [DW:0] d_tmp [3];
  logic [DW+2:0]      m_tmp;

  vrt_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (crd[div_idx]),
    .den  (vs),
    .busy (div_busy),
    .quo  (div_quo),
    .rmd  (div_rmd)
  );

  // Shared multiplier: the first product is dist_c*len_b, the second dist_b*len_c.
  // Each product is built from four 22 by 22 bit partial products, one per cycle.
  always_comb begin
    cand = cmp_sel ? 2'd2 : 2'd1;
    base = cmp_sel ? best : 2'd0;
    if (!prod_idx) begin
      mul_a = bdist[cand];
      mul_b = len[base];
    end else begin
      mul_a = bdist[base];
      mul_b = len[cand];
    end
    case (part)
      2'd0: begin
        pa = mul_a[HW-1:0];
        pb = mul_b[HW-1:0];
      end
      2'd1: begin
        pa = mul_a[DW-1:HW];
        pb = mul_b[HW-1:0];
      end
      2'd2: begin
        pa = mul_a[HW-1:0];
        pb = mul_b[DW-1:HW];
      end
      default: begin
        pa = mul_a[DW-1:HW];
        pb = mul_b[DW-1:HW];
      end
    endcase
    pp = DW'(pa) * DW'(pb);
    case (part)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << DW;
      default: pp_sh = PW'(pp) << HW;
    endcase
    acc_sum = ((part == 2'd0) ? {PW{1'b0}} : acc) + pp_sh;
    // Candidate is earlier than the current best when dist_c*len_b < dist_b*len_c.
    better = (len[cand] != '0) && ((len[base] == '0) || (prod_a < acc));
  end

  always_comb begin
    at_end = (cellv[0] == cellv[3]) && (cellv[1] == cellv[4]) && (cellv[2] == cellv[5]);
    capped = !at_end && ((k + 1'b1) >= limit);
  end

  always_comb begin
    m_tmp = '0;
    for (int a = 0; a < 3; a++) begin
      d_tmp[a] = cellv[a+3] - cellv[a];
      m_tmp = m_tmp + (d_tmp[a][DW] ? (DW+3)'(-d_tmp[a]) : (DW+3)'(d_tmp[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vsize <= VSIZE_RESET;
    end else begin
      state <= state_next;
      if (vsize_we) begin
        vsize <= vsize_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          crd[0] <= (DW+1)'(signed'(origin_x)) <<< CSHIFT;
          crd[1] <= (DW+1)'(signed'(origin_y)) <<< CSHIFT;
          crd[2] <= (DW+1)'(signed'(origin_z)) <<< CSHIFT;
          crd[3] <= (DW+1)'(signed'(end_x)) <<< CSHIFT;
          crd[4] <= (DW+1)'(signed'(end_y)) <<< CSHIFT;
          crd[5] <= (DW+1)'(signed'(end_z)) <<< CSHIFT;
          vs      <= DW'(vsize == '0 ? VSIZE_W'(1) : vsize) << VSHIFT;
          div_idx <= '0;
          k       <= '0;
        end
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          cellv[div_idx] <= div_quo;
          // The origin remainder is the distance back to the lower boundary.
          if (div_idx < 3'd3) begin
            bdist[div_idx[1:0]] <= div_rmd;
          end
          div_idx <= div_idx + 1'b1;
        end
      end
      ST_SETUP: begin
        for (int a = 0; a < 3; a++) begin
          if (crd[a+3] > crd[a]) begin
            dir[a]   <= 2'b01;
            len[a]   <= DW'(crd[a+3] - crd[a]);
            bdist[a] <= vs - bdist[a];
          end else if (crd[a+3] < crd[a]) begin
            dir[a]   <= 2'b11;
            len[a]   <= DW'(crd[a] - crd[a+3]);
          end else begin
            dir[a]   <= 2'b00;
            len[a]   <= '0;
            bdist[a] <= '0;
          end
        end
        manh <= m_tmp;
      end
      ST_EMIT: begin
        best     <= 2'd0;
        cmp_sel  <= 1'b0;
        prod_idx <= 1'b0;
        part     <= 2'd0;
        if (manh + 2 < (DW+3)'(MAX_VOXELS)) begin
          limit <= KW'(manh + 2);
        end else begin
          limit <= KW'(MAX_VOXELS);
        end
      end
      ST_MUL: begin
        acc  <= acc_sum;
        part <= part + 1'b1;
        if (part == 2'd3 && !prod_idx) begin
          prod_a   <= acc_sum;
          prod_idx <= 1'b1;
        end
      end
      ST_CMP: begin
        if (better) best <= cand;
        cmp_sel  <= 1'b1;
        prod_idx <= 1'b0;
      end
      ST_ADVANCE: begin
        for (int a = 0; a < 3; a++) begin
          if (best == 2'(a)) begin
            cellv[a] <= dir[a][1] ? cellv[a] - (DW+1)'(1) :
                        (dir[a][0] ? cellv[a] + (DW+1)'(1) : cellv[a]);
            bdist[a] <= bdist[a] + vs;
          end
        end
        k <= k + 1'b1;
      end
      default: ;
    endcase
  end

  // Limit is loaded in every emit state; the first one of a ray keeps out_valid low so limit holds its value first.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_emit <= 1'b0;
    end else if (state == ST_SETUP) begin
      first_emit <= 1'b1;
    end else if (state == ST_EMIT) begin
      first_emit <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = (div_idx == 3'd5) ? ST_SETUP : ST_DIV_START;
        end
      end
      ST_SETUP: state_next = ST_EMIT;
      ST_EMIT: begin
        out_valid = !first_emit;
        if (first_emit) begin
          state_next = ST_EMIT;
        end else if (out_ready) begin
          state_next = (at_end || capped) ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (part == 2'd3 && prod_idx) state_next = ST_CMP;
      end
      ST_CMP:     state_next = cmp_sel ? ST_ADVANCE : ST_MUL;
      ST_ADVANCE: state_next = ST_EMIT;
      default:    state_next = ST_IDLE;
    endcase
  end

  assign cell_x    = cellv[0][COORD_W-1:0];
  assign cell_y    = cellv[1][COORD_W-1:0];
  assign cell_z    = cellv[2][COORD_W-1:0];
  assign last      = at_end || capped;
  assign truncated = capped;
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for voxel_ray_traversal_3d_top: directed and random rays
// are checked against an exact fixed-point DDA predictor. Depends on vrt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import vrt_pkg::*;

  // Rays are Q15.16, so coordinates and the voxel size already share a binary point.
  localparam int CAP = MAX_VOXELS_DEF;

  typedef struct {
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic                      is_last, is_trunc;
  } voxel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vsize_we = 1'b0;
  logic [VSIZE_W-1:0] vsize_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [COORD_W-1:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] cell_x, cell_y, cell_z;
  logic last, truncated;

  // Shadow copy of the voxel size register, as the predictor sees it.
  logic [VSIZE_W-1:0] vsize_shadow = VSIZE_RESET;
  voxel_t visited_q[$];
  int mismatches = 0;
  int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
  bit quiet_rx = 1'b0;   // when set the receiver never stalls

  voxel_ray_traversal_3d_top dut (
    .clk, .rst, .vsize_we, .vsize_wdata,
    .in_valid, .in_ready, .origin_x, .origin_y, .origin_z, .end_x, .end_y, .end_z,
    .out_valid, .out_ready, .cell_x, .cell_y, .cell_z, .last, .truncated
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** voxel_ray_traversal_3d_top: FAILED **");
    $finish;
  end

  // True when crossing na/da comes strictly before nb/db; a zero length never crosses.
  function automatic bit crosses_first(longint unsigned na, longint unsigned da,
                                       longint unsigned nb, longint unsigned db);
    logic [127:0] lhs, rhs;
    if (da == 0) return 1'b0;
    if (db == 0) return 1'b1;
    lhs = {64'd0, na} * {64'd0, db};
    rhs = {64'd0, nb} * {64'd0, da};
    return lhs < rhs;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Walks the grid for one ray and queues every voxel that should come out.
  function automatic void walk_ray(logic signed [COORD_W-1:0] p0[3],
                                   logic signed [COORD_W-1:0] p1[3]);
    longint o[3], f[3], cur[3], goal[3], stp[3];
    longint unsigned bdist[3], len[3];
    longint unsigned manh, lim;
    longint vs, diff;
    int best;
    bit at_end, capped;
    voxel_t v;
    vs = (vsize_shadow == 0) ? 1 : longint'(vsize_shadow);
    manh = 0;
    for (int a = 0; a < 3; a++) begin
      o[a] = longint'(p0[a]);
      f[a] = longint'(p1[a]);
      cur[a] = floor_quot(o[a], vs);
      goal[a] = floor_quot(f[a], vs);
      diff = f[a] - o[a];
      if (diff > 0) begin
        stp[a] = 1; len[a] = diff; bdist[a] = (cur[a] + 1) * vs - o[a];
      end else if (diff < 0) begin
        stp[a] = -1; len[a] = -diff; bdist[a] = o[a] - cur[a] * vs;
      end else begin
        stp[a] = 0; len[a] = 0; bdist[a] = 0;
      end
      diff = goal[a] - cur[a];
      manh += (diff < 0) ? -diff : diff;
    end
    lim = manh + 2;
    if (lim > CAP) lim = CAP;
    for (int k = 0; ; k++) begin
      at_end = (cur[0] == goal[0]) && (cur[1] == goal[1]) && (cur[2] == goal[2]);
      capped = !at_end && (k + 1 >= lim);
      v.cx = cur[0][31:0];
      v.cy = cur[1][31:0];
      v.cz = cur[2][31:0];
      v.is_last = at_end || capped;
      v.is_trunc = capped;
      visited_q.insert(visited_q.size(), v);
      if (at_end || capped) return;
      best = 0;
      if (crosses_first(bdist[1], len[1], bdist[best], len[best])) best = 1;
      if (crosses_first(bdist[2], len[2], bdist[best], len[best])) best = 2;
      cur[best] += stp[best];
      bdist[best] += vs;
    end
  endfunction

  // Offers one ray and holds it until the transfer, then predicts its voxels.
  // A gap of zero keeps in_valid high so the next ray follows back to back.
  task automatic send_ray(logic signed [COORD_W-1:0] p0[3],
                          logic signed [COORD_W-1:0] p1[3], int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    origin_x <= p0[0]; origin_y <= p0[1]; origin_z <= p0[2];
    end_x <= p1[0]; end_y <= p1[1]; end_z <= p1[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_ray(p0, p1);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (visited_q.size() != 0) @(posedge clk);
    // The block is idle again once its last transfer is taken.
    repeat (20) @(posedge clk);
  endtask

  // Register writes only happen once the block is idle.
  task automatic set_vsize(logic [VSIZE_W-1:0] value);
    drain();
    @(negedge clk);
    vsize_we <= 1'b1;
    vsize_wdata <= value;
    @(negedge clk);
    vsize_we <= 1'b0;
    vsize_shadow = value;
  endtask

  task automatic ray6(int x0, int y0, int z0, int x1, int y1, int z1);
    logic signed [COORD_W-1:0] p0[3], p1[3];
    p0 = '{x0, y0, z0};
    p1 = '{x1, y1, z1};
    send_ray(p0, p1, $urandom_range(0, 3));
  endtask

  task automatic test_extremes;
    int vs;
    vs = 6554;
    ray6(0, 0, 0, 0, 0, 0);
    ray6(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    ray6(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'h80000000);
    ray6(-1, -1, -1, 1, 1, 1);
    ray6(5 * vs + 7, 3, -3, 5 * vs + 9, 4, -2);
    ray6(0, 0, 0, 10 * vs + 1, 0, 0);
    ray6(0, 0, 0, 0, -7 * vs - 1, 0);
    ray6(1, 1, 1, 1, 1, 9 * vs);
  endtask

  // Exact diagonals tie on every boundary; ending on a boundary steps past the end.
  task automatic test_ties;
    int vs;
    vs = 6554;
    ray6(0, 0, 0, 3 * vs, 3 * vs, 3 * vs);
    ray6(1, 1, 1, 3 * vs + 1, 3 * vs + 1, 0);
    ray6(vs, vs, vs, -2 * vs, -2 * vs, -2 * vs);
    ray6(10, 10, 0, 2 * vs, 2 * vs, 0);
    ray6(-5, 7, 0, 4 * vs - 5, -4 * vs + 7, 0);
  endtask

  task automatic random_ray(int gap);
    logic signed [COORD_W-1:0] p0[3], p1[3];
    int span;
    span = (vsize_shadow == 0) ? 1 : int'(vsize_shadow);
    for (int a = 0; a < 3; a++) begin
      p0[a] = $urandom;
      case ($urandom_range(0, 9))
        0: p1[a] = $urandom;
        1: p1[a] = p0[a];
        2: p1[a] = p0[a] + (($urandom_range(0, 1) != 0) ? span : -span);
        default: p1[a] = p0[a] + ($urandom_range(0, 8 * span) - 4 * span);
      endcase
    end
    send_ray(p0, p1, gap);
  endtask

  // Bursts of back to back rays separated by random idle gaps.
  task automatic test_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 6);
      for (int i = 0; i < burst && count > 0; i++, count--)
        random_ray((i == burst - 1) ? $urandom_range(1, 40) : 0);
    end
  endtask

  task automatic test_cell_sizes;
    set_vsize(VSIZE_W'(1));
    test_random(8);
    set_vsize(VSIZE_W'(0));
    ray6(0, 0, 0, 3, -2, 1);
    test_random(6);
    set_vsize(23'd4194304);
    ray6(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 1);
    test_random(20);
    set_vsize(23'h7fffff);
    test_random(10);
    for (int i = 0; i < 4; i++) begin
      set_vsize(VSIZE_W'($urandom_range(1, 4194304)));
      test_random(40);
    end
    set_vsize(VSIZE_RESET);
  endtask

  // The receiver holds off while rays keep arriving, so in_ready must drop.
  task automatic test_backpressure;
    drain();
    hold_cycles = 3000;
    for (int i = 0; i < 6; i++) random_ray(0);
    drain();
  endtask

  task automatic test_clean_flow;
    quiet_rx = 1'b1;
    test_random(30);
    drain();
    quiet_rx = 1'b0;
  endtask

  // Receiver: long hold-off when asked, otherwise stalls in phases of its own.
  initial begin
    int phase_left, stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 300);
        stall_pct = $urandom_range(0, 3) * 20;
      end
      phase_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (quiet_rx) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Each output transfer is checked against the oldest predicted voxel.
  always @(posedge clk) begin
    voxel_t want;
    if (!rst && out_valid && out_ready) begin
      if (visited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected voxel (%0d,%0d,%0d) last=%b truncated=%b",
                   cell_x, cell_y, cell_z, last, truncated);
      end else begin
        want = visited_q.pop_front();
        if (cell_x !== want.cx || cell_y !== want.cy || cell_z !== want.cz ||
            last !== want.is_last || truncated !== want.is_trunc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("voxel mismatch: expected (%0d,%0d,%0d) l=%b t=%b got (%0d,%0d,%0d) l=%b t=%b",
                     want.cx, want.cy, want.cz, want.is_last, want.is_trunc,
                     cell_x, cell_y, cell_z, last, truncated);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_ties();
    test_random(120);
    test_cell_sizes();
    test_backpressure();
    test_clean_flow();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && visited_q.size() == 0)
      $display("** voxel_ray_traversal_3d_top: PASSED **");
    else
      $display("** voxel_ray_traversal_3d_top: FAILED **");
    $finish;
  end

endmodule
